// ===== hdl/bccs_pkg.sv =====
package bccs_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam int IN_DATA_W   = 176;
    localparam int OUT_DATA_W  = 256;
    localparam int OUT_USER_W  = 4;

    localparam logic [15:0] T_BL_MASK    = 16'hF800;
    localparam logic [15:0] T_BL_HI      = 16'hF000;
    localparam logic [15:0] T_BL_LO      = 16'hF800;
    localparam logic [15:0] T_BX_MASK    = 16'hFF87;
    localparam logic [15:0] T_BX         = 16'h4700;
    localparam logic [15:0] T_POP_MASK   = 16'hFF00;
    localparam logic [15:0] T_POP_PC     = 16'hBD00;
    localparam logic [15:0] T_B_MASK     = 16'hF800;
    localparam logic [15:0] T_B          = 16'hE000;
    localparam logic [15:0] T_BCOND_MASK = 16'hF000;
    localparam logic [15:0] T_BCOND      = 16'hD000;
    localparam logic [3:0]  COND_AL      = 4'hE;
    localparam logic [31:0] A_BX_MASK    = 32'h0FFFFFF0;
    localparam logic [31:0] A_BX         = 32'h012FFF10;
    localparam logic [31:0] A_B_MASK     = 32'h0E000000;
    localparam logic [31:0] A_B          = 32'h0A000000;
    localparam logic [31:0] A_LINK_BIT   = 32'h01000000;
    localparam logic [31:0] EXC_LIMIT    = 32'h00000040;

    typedef enum logic {
        OP_RETIRE = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        KIND_B     = 3'd0,
        KIND_BCOND = 3'd1,
        KIND_CALL  = 3'd2,
        KIND_RET   = 3'd3,
        KIND_BX    = 3'd4,
        KIND_EXC   = 3'd5
    } t_kind;

    typedef struct packed {
        logic             found;
        t_kind            kind;
        logic [31:0]      site;
        logic [31:0]      target;
        logic [15:0]      depth;
        logic [31:0]      link;
        logic [31:0]      sp;
        logic [4:0]       mode;
        logic [31:0]      step;
        logic [31:0]      next_exp;
        logic [8:0]       frame_count;
        logic             hit;
        logic             mem_we;
        logic [IDX_W-1:0] mem_addr;
    } t_rec;

endpackage

// ===== hdl/branch_classifier_shadow_call_stack.sv =====
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  retire step or stack frame read
// m_axis    out        m_axis_tvalid / m_axis_tready  one trace record per item
// cfg       in         i_cfg_we                       enable register
//
// One item is accepted per cycle while the queue has room; its record passes through
// the queue and the output register before it is valid at the output.
// Classification and the stack pointer update happen at acceptance, and the stack
// memory write or frame read happens in the output stage through one port.
// A four-entry queue separates the two parts, so the input stalls only when it fills.
// Reset is synchronous and active low; the stack memory is not cleared.
module branch_classifier_shadow_call_stack (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pc_reg, thumb, prev_word, link_value, stack_value, mode_bits, step_number,
    // frame_index
    input  logic [bccs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // site_addr, target_addr, call_depth, link_out, sp_out, mode_out, step_out,
    // next_expected, frame_value, frame_count
    output logic [bccs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // branch_found, branch_kind
    output logic [bccs_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    logic           w_accept;
    logic           w_full;
    logic           w_q_valid;
    logic           w_pop;
    bccs_pkg::t_rec w_front_rec;
    bccs_pkg::t_rec w_q_rec;

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && !w_full;

    bccs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (w_accept),
        .i_op          (bccs_pkg::t_op'(s_axis_tuser)),
        .i_pc_reg      (s_axis_tdata[31:0]),
        .i_thumb       (s_axis_tdata[32]),
        .i_prev_word   (s_axis_tdata[64:33]),
        .i_link_value  (s_axis_tdata[96:65]),
        .i_stack_value (s_axis_tdata[128:97]),
        .i_mode_bits   (s_axis_tdata[133:129]),
        .i_step_number (s_axis_tdata[165:134]),
        .i_frame_index (s_axis_tdata[173:166]),
        .o_rec         (w_front_rec)
    );

    bccs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_wdata (w_front_rec),
        .o_full  (w_full),
        .i_rd    (w_pop),
        .o_valid (w_q_valid),
        .o_rdata (w_q_rec)
    );

    bccs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_rec         (w_q_rec),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== hdl/bccs_front.sv =====
module bccs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_accept,
    input  bccs_pkg::t_op        i_op,
    input  logic [31:0]          i_pc_reg,
    input  logic                 i_thumb,
    input  logic [31:0]          i_prev_word,
    input  logic [31:0]          i_link_value,
    input  logic [31:0]          i_stack_value,
    input  logic [4:0]           i_mode_bits,
    input  logic [31:0]          i_step_number,
    input  logic [7:0]           i_frame_index,
    output bccs_pkg::t_rec       o_rec
);

    logic                       r_enable;
    logic [31:0]                r_exp_pc;
    logic                       r_exp_valid;
    logic [15:0]                r_depth;
    logic [bccs_pkg::CNT_W-1:0] r_count;

    logic [31:0]                n_exp_pc;
    logic [15:0]                n_depth;
    logic [bccs_pkg::CNT_W-1:0] n_count;

    logic [31:0]     w_pc;
    logic [31:0]     w_site;
    logic [15:0]     w_h;
    logic [15:0]     w_hp;
    logic            w_act;
    logic            w_branch;
    logic            w_read;
    logic            w_push;
    bccs_pkg::t_kind w_kind;

    assign w_pc     = i_pc_reg - (i_thumb ? 32'd4 : 32'd8);
    assign w_h      = i_prev_word[15:0];
    assign w_hp     = i_prev_word[31:16];
    assign w_read   = (i_op == bccs_pkg::OP_READ);
    assign w_act    = r_enable && !w_read;
    assign w_branch = w_act && r_exp_valid && (w_pc != r_exp_pc);

    always_comb begin
        w_kind = bccs_pkg::KIND_BX;
        w_site = r_exp_pc - 32'd2;
        if (w_pc < bccs_pkg::EXC_LIMIT) begin
            w_kind = bccs_pkg::KIND_EXC;
        end else if ((w_hp & bccs_pkg::T_BL_MASK) == bccs_pkg::T_BL_HI &&
                     (w_h & bccs_pkg::T_BL_MASK) == bccs_pkg::T_BL_LO) begin
            w_kind = bccs_pkg::KIND_CALL;
            w_site = r_exp_pc - 32'd4;
        end else if ((w_h & bccs_pkg::T_BX_MASK) == bccs_pkg::T_BX) begin
            w_kind = bccs_pkg::KIND_BX;
        end else if ((w_h & bccs_pkg::T_POP_MASK) == bccs_pkg::T_POP_PC) begin
            w_kind = bccs_pkg::KIND_RET;
        end else if ((w_h & bccs_pkg::T_B_MASK) == bccs_pkg::T_B) begin
            w_kind = bccs_pkg::KIND_B;
        end else if ((w_h & bccs_pkg::T_BCOND_MASK) == bccs_pkg::T_BCOND &&
                     w_h[11:8] < bccs_pkg::COND_AL) begin
            w_kind = bccs_pkg::KIND_BCOND;
        end else if ((i_prev_word & bccs_pkg::A_BX_MASK) == bccs_pkg::A_BX) begin
            w_kind = bccs_pkg::KIND_BX;
            w_site = r_exp_pc - 32'd4;
        end else if ((i_prev_word & bccs_pkg::A_B_MASK) == bccs_pkg::A_B) begin
            w_site = r_exp_pc - 32'd4;
            if ((i_prev_word & bccs_pkg::A_LINK_BIT) != 32'd0) begin
                w_kind = bccs_pkg::KIND_CALL;
            end else if (i_prev_word[31:28] != bccs_pkg::COND_AL) begin
                w_kind = bccs_pkg::KIND_BCOND;
            end else begin
                w_kind = bccs_pkg::KIND_B;
            end
        end
    end

    always_comb begin
        n_depth = r_depth;
        n_count = r_count;
        w_push  = 1'b0;
        if (w_branch) begin
            case (w_kind) inside
                bccs_pkg::KIND_CALL: begin
                    n_depth = r_depth + 16'd1;
                    if (r_count < bccs_pkg::CNT_W'(bccs_pkg::STACK_DEPTH)) begin
                        w_push  = 1'b1;
                        n_count = r_count + bccs_pkg::CNT_W'(1);
                    end
                end
                bccs_pkg::KIND_RET, bccs_pkg::KIND_BX: begin
                    if (r_depth != 16'd0) begin
                        n_depth = r_depth - 16'd1;
                    end
                    if (r_count != '0) begin
                        n_count = r_count - bccs_pkg::CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
        n_exp_pc = w_act ? (w_pc + (i_thumb ? 32'd2 : 32'd4)) : r_exp_pc;
    end

    always_comb begin
        o_rec             = '0;
        o_rec.depth       = n_depth;
        o_rec.next_exp    = n_exp_pc;
        o_rec.frame_count = r_enable ? 9'(n_count) : 9'd0;
        o_rec.hit         = w_read && r_enable && (32'(i_frame_index) < 32'(r_count));
        o_rec.mem_we      = w_push;
        o_rec.mem_addr    = w_push ? bccs_pkg::IDX_W'(r_count)
                                   : bccs_pkg::IDX_W'(i_frame_index);
        if (w_branch) begin
            o_rec.found  = 1'b1;
            o_rec.kind   = w_kind;
            o_rec.site   = w_site;
            o_rec.target = w_pc;
            o_rec.link   = i_link_value;
            o_rec.sp     = i_stack_value;
            o_rec.mode   = i_mode_bits;
            o_rec.step   = i_step_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_exp_pc    <= '0;
            r_exp_valid <= 1'b0;
            r_depth     <= '0;
            r_count     <= '0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
            if (i_cfg_wdata) begin
                r_exp_pc    <= '0;
                r_exp_valid <= 1'b0;
                r_depth     <= '0;
                r_count     <= '0;
            end
        end else if (i_accept) begin
            r_exp_pc <= n_exp_pc;
            r_depth  <= n_depth;
            r_count  <= n_count;
            if (w_act) begin
                r_exp_valid <= 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bccs_pkg::CNT_W'(bccs_pkg::STACK_DEPTH))
        else $error("shadow stack count beyond its depth");

    a_arm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_wdata |=> r_depth == '0 && r_count == '0 && !r_exp_valid)
        else $error("arming did not clear the trace state");

    a_plain_branch_keeps_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_cfg_we && w_branch &&
        (w_kind == bccs_pkg::KIND_B || w_kind == bccs_pkg::KIND_BCOND ||
         w_kind == bccs_pkg::KIND_EXC)
        |=> $stable(r_count) && $stable(r_depth))
        else $error("non-call, non-return branch changed the stack");

endmodule

// ===== hdl/bccs_queue.sv =====
module bccs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  bccs_pkg::t_rec i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output bccs_pkg::t_rec o_rdata
);

    bccs_pkg::t_rec                r_slot [bccs_pkg::Q_DEPTH];
    logic [bccs_pkg::Q_PTR_W-1:0]  r_wptr;
    logic [bccs_pkg::Q_PTR_W-1:0]  r_rptr;
    logic [bccs_pkg::Q_CNT_W-1:0]  r_count;

    assign o_full  = (r_count == bccs_pkg::Q_CNT_W'(bccs_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + bccs_pkg::Q_PTR_W'(1);
            end
            if (i_rd) begin
                r_rptr <= r_rptr + bccs_pkg::Q_PTR_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + bccs_pkg::Q_CNT_W'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - bccs_pkg::Q_CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full || i_rd)
        else $error("write into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_valid)
        else $error("read from an empty queue");

endmodule

// ===== hdl/bccs_back.sv =====
module bccs_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  bccs_pkg::t_rec                      i_rec,
    output logic                                o_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bccs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [bccs_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    logic [31:0]    r_stack [bccs_pkg::STACK_DEPTH];
    logic [31:0]    r_rdata;
    logic           r_valid;
    bccs_pkg::t_rec r_rec;
    logic [31:0]    w_frame_value;

    assign o_pop = i_valid && (!r_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_rec.mem_we) begin
            r_stack[i_rec.mem_addr] <= i_rec.site;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rdata <= r_stack[i_rec.mem_addr];
            r_rec   <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    assign w_frame_value = r_rec.hit ? r_rdata : 32'd0;

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = {r_rec.kind, r_rec.found};
    assign m_axis_tdata  = {2'b00, r_rec.frame_count, w_frame_value, r_rec.next_exp,
                            r_rec.step, r_rec.mode, r_rec.sp, r_rec.link,
                            r_rec.depth, r_rec.target, r_rec.site};

    a_pop_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped record did not reach the output register");

endmodule

// ===== dv/bccs_trace_checker.sv =====
`timescale 1ns / 1ps

module bccs_trace_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [bccs_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [bccs_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [bccs_pkg::OUT_USER_W-1:0] i_m_tuser,
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic        found;
        logic [2:0]  kind;
        logic [31:0] site;
        logic [31:0] target;
        logic [15:0] depth;
        logic [31:0] link;
        logic [31:0] sp;
        logic [4:0]  mode;
        logic [31:0] step;
        logic [31:0] next_exp;
        logic [31:0] fval;
        logic [8:0]  fcount;
    } t_trace_rec;

    logic        tracing_on;
    logic [31:0] next_pc;
    logic        next_pc_known;
    logic [15:0] call_depth;
    logic [31:0] call_sites [bccs_pkg::STACK_DEPTH];
    int          live_frames;
    t_trace_rec  trace_records_due [$];
    int          mismatches;

    assign o_fail_count = mismatches;

    function automatic void decode_branch(input logic [31:0] pc, input logic [31:0] w,
                                          output bccs_pkg::t_kind kind,
                                          output logic [31:0] site);
        logic [31:0] site2;
        logic [31:0] site4;
        logic [15:0] lo;
        logic [15:0] hi;
        site2 = next_pc - 32'd2;
        site4 = next_pc - 32'd4;
        lo    = w[15:0];
        hi    = w[31:16];
        site  = site2;
        if (pc < bccs_pkg::EXC_LIMIT) begin
            kind = bccs_pkg::KIND_EXC;
        end else if ((hi & bccs_pkg::T_BL_MASK) == bccs_pkg::T_BL_HI &&
                     (lo & bccs_pkg::T_BL_MASK) == bccs_pkg::T_BL_LO) begin
            kind = bccs_pkg::KIND_CALL;
            site = site4;
        end else if ((lo & bccs_pkg::T_BX_MASK) == bccs_pkg::T_BX) begin
            kind = bccs_pkg::KIND_BX;
        end else if ((lo & bccs_pkg::T_POP_MASK) == bccs_pkg::T_POP_PC) begin
            kind = bccs_pkg::KIND_RET;
        end else if ((lo & bccs_pkg::T_B_MASK) == bccs_pkg::T_B) begin
            kind = bccs_pkg::KIND_B;
        end else if ((lo & bccs_pkg::T_BCOND_MASK) == bccs_pkg::T_BCOND &&
                     lo[11:8] < bccs_pkg::COND_AL) begin
            kind = bccs_pkg::KIND_BCOND;
        end else if ((w & bccs_pkg::A_BX_MASK) == bccs_pkg::A_BX) begin
            kind = bccs_pkg::KIND_BX;
            site = site4;
        end else if ((w & bccs_pkg::A_B_MASK) == bccs_pkg::A_B) begin
            site = site4;
            if ((w & bccs_pkg::A_LINK_BIT) != 32'd0) begin
                kind = bccs_pkg::KIND_CALL;
            end else if (w[31:28] != bccs_pkg::COND_AL) begin
                kind = bccs_pkg::KIND_BCOND;
            end else begin
                kind = bccs_pkg::KIND_B;
            end
        end else begin
            kind = bccs_pkg::KIND_BX;
        end
    endfunction

    task automatic trace_step(input logic op, input logic [bccs_pkg::IN_DATA_W-1:0] d,
                              output t_trace_rec r);
        logic [31:0]     pc;
        logic [31:0]     site;
        bccs_pkg::t_kind kind;
        logic            thumb;
        logic [7:0]      fidx;
        thumb = d[32];
        fidx  = d[173:166];
        r     = '0;
        if (op == bccs_pkg::OP_READ) begin
            if (tracing_on) begin
                r.fcount = live_frames[8:0];
                if (int'(fidx) < live_frames) begin
                    r.fval = call_sites[fidx];
                end
            end
        end else if (tracing_on) begin
            pc = d[31:0] - (thumb ? 32'd4 : 32'd8);
            if (next_pc_known && pc != next_pc) begin
                decode_branch(pc, d[64:33], kind, site);
                if (kind == bccs_pkg::KIND_CALL) begin
                    call_depth = call_depth + 16'd1;
                    if (live_frames < bccs_pkg::STACK_DEPTH) begin
                        call_sites[live_frames[7:0]] = site;
                        live_frames++;
                    end
                end else if (kind == bccs_pkg::KIND_RET || kind == bccs_pkg::KIND_BX) begin
                    if (call_depth != 16'd0) begin
                        call_depth = call_depth - 16'd1;
                    end
                    if (live_frames != 0) begin
                        live_frames--;
                    end
                end
                r.found  = 1'b1;
                r.kind   = kind;
                r.site   = site;
                r.target = pc;
                r.link   = d[96:65];
                r.sp     = d[128:97];
                r.mode   = d[133:129];
                r.step   = d[165:134];
            end
            next_pc       = pc + (thumb ? 32'd2 : 32'd4);
            next_pc_known = 1'b1;
            r.fcount      = live_frames[8:0];
        end
        r.depth    = call_depth;
        r.next_exp = next_pc;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_trace_rec want;
        t_trace_rec got;
        if (!i_rst_n) begin
            tracing_on    = 1'b0;
            next_pc       = '0;
            next_pc_known = 1'b0;
            call_depth    = '0;
            live_frames   = 0;
            trace_records_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.found    = i_m_tuser[0];
                got.kind     = i_m_tuser[3:1];
                got.site     = i_m_tdata[31:0];
                got.target   = i_m_tdata[63:32];
                got.depth    = i_m_tdata[79:64];
                got.link     = i_m_tdata[111:80];
                got.sp       = i_m_tdata[143:112];
                got.mode     = i_m_tdata[148:144];
                got.step     = i_m_tdata[180:149];
                got.next_exp = i_m_tdata[212:181];
                got.fval     = i_m_tdata[244:213];
                got.fcount   = i_m_tdata[253:245];
                if (trace_records_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: record transfer with none outstanding", $realtime);
                    end
                end else begin
                    want = trace_records_due.pop_front();
                    check_field("branch_found", 32'(want.found), 32'(got.found));
                    check_field("branch_kind", 32'(want.kind), 32'(got.kind));
                    check_field("site_addr", want.site, got.site);
                    check_field("target_addr", want.target, got.target);
                    check_field("call_depth", 32'(want.depth), 32'(got.depth));
                    check_field("link_out", want.link, got.link);
                    check_field("sp_out", want.sp, got.sp);
                    check_field("mode_out", 32'(want.mode), 32'(got.mode));
                    check_field("step_out", want.step, got.step);
                    check_field("next_expected", want.next_exp, got.next_exp);
                    check_field("frame_value", want.fval, got.fval);
                    check_field("frame_count", 32'(want.fcount), 32'(got.fcount));
                end
            end
            if (i_cfg_we) begin
                tracing_on = i_cfg_wdata;
                if (i_cfg_wdata) begin
                    next_pc       = '0;
                    next_pc_known = 1'b0;
                    call_depth    = '0;
                    live_frames   = 0;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                trace_step(i_s_tuser, i_s_tdata, want);
                trace_records_due.push_back(want);
            end
        end
        o_pending = trace_records_due.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    typedef enum int {
        SH_T_BL,
        SH_T_BX,
        SH_T_POP,
        SH_T_B,
        SH_T_BCOND,
        SH_A_BX,
        SH_A_B,
        SH_JUNK
    } t_shape;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic                            cfg_wdata     = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [bccs_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [bccs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [bccs_pkg::OUT_USER_W-1:0] m_axis_tuser;
    int                              fail_count;
    int                              pending;

    bit                              quiet     = 1'b0;
    bit                              hold_req  = 1'b0;
    bit                              hold_done = 1'b0;
    bit                              thumb_st  = 1'b1;
    logic [31:0]                     drv_exp   = '0;

    branch_classifier_shadow_call_stack dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bccs_trace_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // The long hold-off lets the internal queue fill so that the input stalls.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                hold_done = 1'b1;
                repeat (300) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send(input logic [bccs_pkg::IN_DATA_W-1:0] d, input bccs_pkg::t_op op);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [bccs_pkg::IN_DATA_W-1:0] random_fields();
        logic [bccs_pkg::IN_DATA_W-1:0] d;
        d            = '0;
        d[31:0]      = $urandom;
        d[32]        = 1'($urandom_range(0, 1));
        d[64:33]     = $urandom;
        d[96:65]     = $urandom;
        d[128:97]    = $urandom;
        d[133:129]   = 5'($urandom_range(0, 31));
        d[165:134]   = $urandom;
        d[173:166]   = 8'($urandom_range(0, 255));
        return d;
    endfunction

    task automatic retire(input logic [31:0] pc, input logic [31:0] word);
        logic [bccs_pkg::IN_DATA_W-1:0] d;
        d        = random_fields();
        d[31:0]  = pc + (thumb_st ? 32'd4 : 32'd8);
        d[32]    = thumb_st;
        d[64:33] = word;
        drv_exp  = pc + (thumb_st ? 32'd2 : 32'd4);
        send(d, bccs_pkg::OP_RETIRE);
    endtask

    task automatic read_frame(input logic [7:0] fidx);
        logic [bccs_pkg::IN_DATA_W-1:0] d;
        d          = random_fields();
        d[173:166] = fidx;
        send(d, bccs_pkg::OP_READ);
    endtask

    function automatic logic [31:0] branch_word(input t_shape sh);
        logic [31:0] w;
        logic [15:0] hi;
        logic [15:0] lo;
        w  = $urandom;
        hi = w[31:16];
        lo = w[15:0];
        case (sh)
            SH_T_BL: begin
                hi = bccs_pkg::T_BL_HI | (hi & ~bccs_pkg::T_BL_MASK);
                lo = bccs_pkg::T_BL_LO | (lo & ~bccs_pkg::T_BL_MASK);
            end
            SH_T_BX:    lo = bccs_pkg::T_BX | (lo & ~bccs_pkg::T_BX_MASK);
            SH_T_POP:   lo = bccs_pkg::T_POP_PC | (lo & ~bccs_pkg::T_POP_MASK);
            SH_T_B:     lo = bccs_pkg::T_B | (lo & ~bccs_pkg::T_B_MASK);
            SH_T_BCOND: lo = bccs_pkg::T_BCOND | (lo & ~bccs_pkg::T_BCOND_MASK);
            default: ;
        endcase
        w = {hi, lo};
        if (sh == SH_A_BX) begin
            w = bccs_pkg::A_BX | (w & ~bccs_pkg::A_BX_MASK);
        end else if (sh == SH_A_B) begin
            w = bccs_pkg::A_B | (w & ~bccs_pkg::A_B_MASK);
        end
        return w;
    endfunction

    task automatic branch(input t_shape sh, input bit allow_exc);
        logic [31:0] pc;
        pc = $urandom;
        if (allow_exc && $urandom_range(0, 15) == 0) begin
            pc = $urandom_range(0, 63);
        end
        if (pc == drv_exp) begin
            pc = pc ^ 32'h0000_0100;
        end
        retire(pc, branch_word(sh));
    endtask

    task automatic random_mix(input int n, input int call_pct);
        int r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                thumb_st = !thumb_st;
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                read_frame($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 20)));
            end else if (r < 45) begin
                retire(drv_exp, $urandom);
            end else if ($urandom_range(0, 99) < call_pct) begin
                branch(SH_T_BL, 1'b1);
            end else begin
                branch(t_shape'($urandom_range(0, SH_JUNK)), 1'b1);
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_enable(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Tracing is off after reset: retires change nothing and reads return zero.
        retire(32'h0000_1000, 32'hF000_F800);
        retire(32'h0000_5000, 32'h0000_BD00);
        read_frame(8'd0);
        wait_drained();

        set_enable(1'b1);
        thumb_st = 1'b1;
        retire(32'h0000_1000, $urandom);
        retire(drv_exp, 32'h0000_0000);
        retire(32'h0000_2000, 32'hF123_F845);
        read_frame(8'd0);
        retire(32'h0000_1004, 32'h1234_4770);
        retire(32'h0000_3000, 32'h0000_BD10);
        retire(32'h0000_4000, 32'h0000_E7FE);
        retire(32'h0000_5000, 32'h0000_D512);
        retire(32'h0000_6000, 32'h0000_DE01);
        thumb_st = 1'b0;
        retire(32'h0000_7000, 32'hE12F_FF1E);
        retire(32'h0000_8000, 32'hEB00_0010);
        retire(32'h0000_9000, 32'hEA00_0020);
        retire(32'h0000_A000, 32'h0A00_0030);
        retire(32'h0000_0000, $urandom);
        retire(32'h0000_B000, 32'h0000_0000);
        thumb_st = 1'b1;
        retire(32'hFFFF_FFFB, 32'hFFFF_FFFF);
        thumb_st = 1'b0;
        retire(32'hFFFF_FFF8, 32'hFFFF_FFFF);
        read_frame(8'd1);
        read_frame(8'd255);
        read_frame(8'd0);

        hold_req = 1'b1;
        random_mix(300, 15);
        wait_drained();

        set_enable(1'b0);
        random_mix(100, 30);
        wait_drained();

        // Re-arming clears the trace; a call-heavy stretch then grows the stack.
        set_enable(1'b1);
        random_mix(350, 90);
        random_mix(150, 5);
        random_mix(100, 30);

        // A long run of calls fills the shadow stack and keeps calling while it is full.
        quiet = 1'b1;
        for (int i = 0; i < 280; i++) begin
            branch(SH_T_BL, 1'b0);
        end
        for (int i = 0; i < 12; i++) begin
            branch(SH_T_POP, 1'b0);
        end
        read_frame(8'd255);
        read_frame(8'd243);
        random_mix(60, 30);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
